// ===== sv/vst_pkg.sv =====
// shared types and constants for the statement tokenizer
package vst_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_QUERY = 8'h3F;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TOO_MANY   = 3'd1;
    localparam logic [2:0] ST_EQUAL      = 3'd2;
    localparam logic [2:0] ST_COLON      = 3'd3;
    localparam logic [2:0] ST_QUERY_TEXT = 3'd4;

    localparam int RES_DEPTH = 4;
    localparam int RES_PW    = $clog2(RES_DEPTH);
    localparam int RES_CW    = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic       kind;
        logic [4:0] field_index;
        logic [9:0] field_first;
        logic [9:0] field_final;
        logic       field_empty;
        logic       is_query;
        logic [4:0] field_count;
        logic [2:0] status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

// ===== sv/vst_core.sv =====
// statement state and result generation for one byte
module vst_core #(
    parameter int MAX_FIELDS   = 24,
    parameter int MAX_STMT_LEN = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [7:0]     i_ch,
    output vst_pkg::t_push o_push
);

    localparam int PW = $clog2(MAX_STMT_LEN);
    localparam int CW = $clog2(MAX_FIELDS + 1);
    localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_STMT_LEN - 1);
    localparam logic [CW-1:0] FIELD_LIMIT = CW'(MAX_FIELDS);

    logic [PW-1:0] r_pos, n_pos;
    logic          r_span_valid, n_span_valid;
    logic [PW-1:0] r_span_first, n_span_first;
    logic [PW-1:0] r_span_final, n_span_final;
    logic [CW-1:0] r_count, n_count;
    logic          r_query, n_query;
    logic [2:0]    r_err, n_err;

    logic          is_end;
    logic          is_blank;
    logic          fail_many;
    logic          fail_eq;
    logic          fail_col;
    logic [CW-1:0] count_inc;
    logic [PW+9:0] pos_ext;
    logic [PW+9:0] first_ext;
    logic [PW+9:0] final_ext;
    logic [CW+4:0] count_ext;
    logic [CW+4:0] count_inc_ext;
    vst_pkg::t_result rec;
    vst_pkg::t_result stat;

    assign is_end    = (i_ch == vst_pkg::CH_NUL) || (i_ch == vst_pkg::CH_SEMI);
    assign is_blank  = !is_end && ((i_ch <= vst_pkg::CH_SPACE) || i_ch[7]);
    assign fail_many = r_count >= FIELD_LIMIT;
    assign fail_eq   = (i_ch == vst_pkg::CH_EQUAL) && (r_count != '0);
    assign fail_col  = (i_ch == vst_pkg::CH_COLON) && (r_count == '0);
    assign count_inc = r_count + CW'(1);

    assign pos_ext       = {10'b0, r_pos};
    assign first_ext     = {10'b0, r_span_first};
    assign final_ext     = {10'b0, r_span_final};
    assign count_ext     = {5'b0, r_count};
    assign count_inc_ext = {5'b0, count_inc};

    always_comb begin
        rec.kind        = vst_pkg::KIND_RECORD;
        rec.field_index = count_ext[4:0];
        rec.field_first = r_span_valid ? first_ext[9:0] : pos_ext[9:0];
        rec.field_final = r_span_valid ? final_ext[9:0] : pos_ext[9:0];
        rec.field_empty = !r_span_valid;
        rec.is_query    = r_query;
        rec.field_count = count_inc_ext[4:0];
        rec.status      = vst_pkg::ST_OK;
        rec.last        = 1'b1;

        stat.kind        = vst_pkg::KIND_STATUS;
        stat.field_index = 5'd0;
        stat.field_first = 10'd0;
        stat.field_final = 10'd0;
        stat.field_empty = 1'b0;
        stat.is_query    = r_query;
        stat.field_count = count_ext[4:0];
        stat.status      = r_err;
        stat.last        = 1'b1;

        o_push.num  = 2'd0;
        o_push.res0 = rec;
        o_push.res1 = stat;

        n_pos        = r_pos;
        n_span_valid = r_span_valid;
        n_span_first = r_span_first;
        n_span_final = r_span_final;
        n_count      = r_count;
        n_query      = r_query;
        n_err        = r_err;

        if (i_go) begin
            if (is_end) begin
                if (r_pos == '0 && r_err == vst_pkg::ST_OK) begin
                    o_push.num  = 2'd1;
                    o_push.res0 = stat;
                end else if (r_err == vst_pkg::ST_OK && !fail_many) begin
                    o_push.num         = 2'd2;
                    o_push.res0.last   = 1'b0;
                    o_push.res1.field_count = count_inc_ext[4:0];
                end else begin
                    o_push.num  = 2'd1;
                    o_push.res0 = stat;
                    if (r_err == vst_pkg::ST_OK) begin
                        o_push.res0.status = vst_pkg::ST_TOO_MANY;
                    end
                end
                n_pos        = '0;
                n_span_valid = 1'b0;
                n_span_first = '0;
                n_span_final = '0;
                n_count      = '0;
                n_query      = 1'b0;
                n_err        = vst_pkg::ST_OK;
            end else begin
                if (r_err == vst_pkg::ST_OK && !is_blank) begin
                    if (r_query) begin
                        n_err = vst_pkg::ST_QUERY_TEXT;
                    end else if (i_ch == vst_pkg::CH_QUERY) begin
                        n_query = 1'b1;
                    end else if (i_ch == vst_pkg::CH_COLON || i_ch == vst_pkg::CH_EQUAL) begin
                        if (fail_many) begin
                            n_err = vst_pkg::ST_TOO_MANY;
                        end else if (fail_eq) begin
                            n_err = vst_pkg::ST_EQUAL;
                        end else if (fail_col) begin
                            n_err = vst_pkg::ST_COLON;
                        end else begin
                            o_push.num   = 2'd1;
                            n_span_valid = 1'b0;
                            n_span_first = '0;
                            n_span_final = '0;
                            n_count      = count_inc;
                        end
                    end else begin
                        if (!r_span_valid) begin
                            n_span_valid = 1'b1;
                            n_span_first = r_pos;
                        end
                        n_span_final = r_pos;
                    end
                end
                if (r_pos < POS_LIMIT) begin
                    n_pos = r_pos + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_span_valid <= 1'b0;
            r_span_first <= '0;
            r_span_final <= '0;
            r_count      <= '0;
            r_query      <= 1'b0;
            r_err        <= vst_pkg::ST_OK;
        end else begin
            r_pos        <= n_pos;
            r_span_valid <= n_span_valid;
            r_span_first <= n_span_first;
            r_span_final <= n_span_final;
            r_count      <= n_count;
            r_query      <= n_query;
            r_err        <= n_err;
        end
    end

endmodule

// ===== sv/vst_res_fifo.sv =====
// small result queue taking up to two results per cycle
module vst_res_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vst_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output vst_pkg::t_result o_head
);

    vst_pkg::t_result r_mem [vst_pkg::RES_DEPTH];

    logic [vst_pkg::RES_PW-1:0] r_wr, n_wr;
    logic [vst_pkg::RES_PW-1:0] r_rd, n_rd;
    logic [vst_pkg::RES_CW-1:0] r_count, n_count;
    logic [vst_pkg::RES_PW-1:0] wr_next;

    assign wr_next = r_wr + vst_pkg::RES_PW'(1);
    assign o_valid = r_count != '0;
    assign o_room  = r_count <= vst_pkg::RES_CW'(vst_pkg::RES_DEPTH - 2);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr + vst_pkg::RES_PW'(i_push.num);
        n_rd    = i_pop ? r_rd + vst_pkg::RES_PW'(1) : r_rd;
        n_count = r_count + vst_pkg::RES_CW'(i_push.num)
                  - vst_pkg::RES_CW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== sv/vsis_statement_tokenizer.sv =====
// top level of the statement tokenizer: input register, core and result queue
// Takes one statement byte per request and splits the statement into trimmed
// fields at ':' and '=' and at the end byte (0 or ';'), giving a field record
// for each field closed and a status request at the end of the statement.
// A byte is taken every cycle and registered before its results are queued.
// An end byte that closes a field gives two results, and the single output
// port passes at most one result per cycle, so the input holds off whenever
// the four-entry result queue has fewer than two free places. Offsets are
// reported in their low ten bits and saturate at MAX_STMT_LEN - 1.
module vsis_statement_tokenizer #(
    parameter int MAX_FIELDS   = 24,
    parameter int MAX_STMT_LEN = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_ch,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [4:0] o_field_index,
    output logic [9:0] o_field_first,
    output logic [9:0] o_field_final,
    output logic       o_field_empty,
    output logic       o_is_query,
    output logic [4:0] o_field_count,
    output logic [2:0] o_status,
    output logic       o_last
);

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       w_room;
    logic       w_go;
    logic       w_pop;

    vst_pkg::t_push   w_push;
    vst_pkg::t_result w_head;

    assign w_go       = r_in_valid && w_room;
    assign o_in_ready = !r_in_valid || w_go;
    assign w_pop      = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_ch <= i_ch;
        end
    end

    vst_core #(
        .MAX_FIELDS   (MAX_FIELDS),
        .MAX_STMT_LEN (MAX_STMT_LEN)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_go),
        .i_ch    (r_in_ch),
        .o_push  (w_push)
    );

    vst_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_head  (w_head)
    );

    assign o_kind        = w_head.kind;
    assign o_field_index = w_head.field_index;
    assign o_field_first = w_head.field_first;
    assign o_field_final = w_head.field_final;
    assign o_field_empty = w_head.field_empty;
    assign o_is_query    = w_head.is_query;
    assign o_field_count = w_head.field_count;
    assign o_status      = w_head.status;
    assign o_last        = w_head.last;

    // a status always ends the results of its byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == vst_pkg::KIND_STATUS |-> o_last)
        else $error("status without last mark");

    // a record that is not last is followed at once by the status
    a_record_then_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop && !o_last |=> o_out_valid && o_kind == vst_pkg::KIND_STATUS)
        else $error("record not followed by status");

    // status requests carry no span
    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == vst_pkg::KIND_STATUS
        |-> o_field_index == 5'd0 && !o_field_empty && o_field_first == 10'd0)
        else $error("status carries field data");

endmodule

// ===== test/vst_checker.sv =====
// checker for the statement tokenizer: tracks statements, predicts each result and compares
module vst_checker #(
    parameter int MAX_FIELDS   = 24,
    parameter int MAX_STMT_LEN = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_ch,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic       i_kind,
    input  logic [4:0] i_field_index,
    input  logic [9:0] i_field_first,
    input  logic [9:0] i_field_final,
    input  logic       i_field_empty,
    input  logic       i_is_query,
    input  logic [4:0] i_field_count,
    input  logic [2:0] i_status,
    input  logic       i_last,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_results
);

    localparam int POS_LIMIT = MAX_STMT_LEN - 1;

    int         pos_now;
    logic       span_open;
    int         span_lo;
    int         span_hi;
    int         fields_closed;
    logic       query_flag;
    logic [2:0] stmt_error;

    vst_pkg::t_result expected_q[$];
    vst_pkg::t_result want;
    vst_pkg::t_result got;
    int         mismatches = 0;
    int         checked = 0;

    task automatic clear_statement();
        pos_now       = 0;
        span_open     = 1'b0;
        span_lo       = 0;
        span_hi       = 0;
        fields_closed = 0;
        query_flag    = 1'b0;
        stmt_error    = vst_pkg::ST_OK;
    endtask

    task automatic push_result(input logic kind, input int idx, input int lo, input int hi,
                               input logic empty, input logic [2:0] st, input logic last_flag);
        vst_pkg::t_result r;
        r.kind        = kind;
        r.field_index = 5'(idx);
        r.field_first = 10'(lo);
        r.field_final = 10'(hi);
        r.field_empty = empty;
        r.is_query    = query_flag;
        r.field_count = 5'(fields_closed);
        r.status      = st;
        r.last        = last_flag;
        expected_q.push_back(r);
    endtask

    task automatic close_field(input logic [7:0] c, input logic at_end, input logic last_flag);
        if (fields_closed >= MAX_FIELDS) begin
            stmt_error = vst_pkg::ST_TOO_MANY;
        end else if (!at_end && c == vst_pkg::CH_EQUAL && fields_closed > 0) begin
            stmt_error = vst_pkg::ST_EQUAL;
        end else if (!at_end && c == vst_pkg::CH_COLON && fields_closed == 0) begin
            stmt_error = vst_pkg::ST_COLON;
        end else begin
            fields_closed++;
            if (span_open)
                push_result(vst_pkg::KIND_RECORD, fields_closed - 1, span_lo, span_hi, 1'b0,
                            vst_pkg::ST_OK, last_flag);
            else
                push_result(vst_pkg::KIND_RECORD, fields_closed - 1, pos_now, pos_now, 1'b1,
                            vst_pkg::ST_OK, last_flag);
            span_open = 1'b0;
            span_lo   = 0;
            span_hi   = 0;
        end
    endtask

    task automatic tokenize_byte(input logic [7:0] c);
        logic at_end;
        logic blank;
        at_end = (c == vst_pkg::CH_NUL) || (c == vst_pkg::CH_SEMI);
        blank  = !at_end && (c <= vst_pkg::CH_SPACE || c >= 8'h80);
        if (at_end) begin
            // an empty statement gives only the status
            if (!(pos_now == 0 && stmt_error == vst_pkg::ST_OK) && stmt_error == vst_pkg::ST_OK)
                close_field(c, 1'b1, 1'b0);
            push_result(vst_pkg::KIND_STATUS, 0, 0, 0, 1'b0, stmt_error, 1'b1);
            clear_statement();
        end else begin
            if (stmt_error == vst_pkg::ST_OK && !blank) begin
                if (query_flag) begin
                    stmt_error = vst_pkg::ST_QUERY_TEXT;
                end else if (c == vst_pkg::CH_QUERY) begin
                    query_flag = 1'b1;
                end else if (c == vst_pkg::CH_COLON || c == vst_pkg::CH_EQUAL) begin
                    close_field(c, 1'b0, 1'b1);
                end else begin
                    if (!span_open) begin
                        span_open = 1'b1;
                        span_lo   = pos_now;
                    end
                    span_hi = pos_now;
                end
            end
            if (pos_now < POS_LIMIT)
                pos_now++;
        end
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_statement();
            expected_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                checked++;
                got = {i_kind, i_field_index, i_field_first, i_field_final, i_field_empty,
                       i_is_query, i_field_count, i_status, i_last};
                if (expected_q.size() == 0) begin
                    $error("result with nothing expected: kind %0d status %0d", i_kind,
                           i_status);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("field_index", want.field_index, got.field_index);
                    check_field("field_first", want.field_first, got.field_first);
                    check_field("field_final", want.field_final, got.field_final);
                    check_field("field_empty", want.field_empty, got.field_empty);
                    check_field("is_query", want.is_query, got.is_query);
                    check_field("field_count", want.field_count, got.field_count);
                    check_field("status", want.status, got.status);
                    check_field("last", want.last, got.last);
                end
            end
            if (i_in_valid && i_in_ready)
                tokenize_byte(i_ch);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_q.size();
        o_results    <= checked;
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top for the statement tokenizer: clock, reset, statement stimulus and verdict
module tb_top;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_ch;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_kind;
    logic [4:0] o_field_index;
    logic [9:0] o_field_first;
    logic [9:0] o_field_final;
    logic       o_field_empty;
    logic       o_is_query;
    logic [4:0] o_field_count;
    logic [2:0] o_status;
    logic       o_last;

    int         fail_count;
    int         pending;
    int         results_seen;

    int         bytes_sent = 0;
    int         statements_sent = 0;
    int         long_sent = 0;
    int         send_calm = 0;
    int         take_calm = 0;
    int         taken = 0;
    int         take_gap;
    logic [7:0] stmt_bytes[$];

    // empty statements, field records with blanks, colon and equal misuse,
    // a repeated question mark and a query statement
    logic [7:0] directed_bytes[$] = '{
        vst_pkg::CH_SEMI,
        vst_pkg::CH_NUL,
        "a", vst_pkg::CH_EQUAL, vst_pkg::CH_SPACE, "b", vst_pkg::CH_COLON,
        vst_pkg::CH_SPACE, vst_pkg::CH_SEMI,
        vst_pkg::CH_COLON, 8'h01, "a", vst_pkg::CH_EQUAL, 8'h7F, vst_pkg::CH_SEMI,
        vst_pkg::CH_EQUAL, vst_pkg::CH_EQUAL, vst_pkg::CH_SEMI,
        vst_pkg::CH_QUERY, 8'h80, vst_pkg::CH_QUERY, vst_pkg::CH_NUL,
        "q", vst_pkg::CH_QUERY, 8'hFF, vst_pkg::CH_SEMI
    };

    vsis_statement_tokenizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_ch          (i_ch),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_field_index (o_field_index),
        .o_field_first (o_field_first),
        .o_field_final (o_field_final),
        .o_field_empty (o_field_empty),
        .o_is_query    (o_is_query),
        .o_field_count (o_field_count),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    vst_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_ch          (i_ch),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_kind        (o_kind),
        .i_field_index (o_field_index),
        .i_field_first (o_field_first),
        .i_field_final (o_field_final),
        .i_field_empty (o_field_empty),
        .i_is_query    (o_is_query),
        .i_field_count (o_field_count),
        .i_status      (o_status),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // gap before the next request, with occasional stretches of back-to-back traffic
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] text_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(33, 126));
        while (c == vst_pkg::CH_COLON || c == vst_pkg::CH_SEMI || c == vst_pkg::CH_EQUAL
               || c == vst_pkg::CH_QUERY);
        return c;
    endfunction

    function automatic logic [7:0] blank_byte();
        if ($urandom_range(0, 1))
            return 8'($urandom_range(1, 32));
        return 8'($urandom_range(128, 255));
    endfunction

    task automatic add_field(input int len);
        repeat ($urandom_range(0, 2)) stmt_bytes.push_back(blank_byte());
        for (int k = 0; k < len; k++)
            stmt_bytes.push_back(($urandom_range(0, 4) == 0) ? blank_byte() : text_byte());
        repeat ($urandom_range(0, 2)) stmt_bytes.push_back(blank_byte());
    endtask

    task automatic build_statement(input bit long_form);
        int         kind_draw;
        int         nfields;
        logic [7:0] sep;
        stmt_bytes.delete();
        kind_draw = long_form ? 99 : $urandom_range(0, 99);
        if (kind_draw < 10) begin
            // noise
            repeat ($urandom_range(1, 12)) stmt_bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            if (long_form)
                nfields = 12;
            else if ($urandom_range(0, 7) == 0)
                nfields = $urandom_range(22, 27);
            else
                nfields = $urandom_range(1, 5);
            for (int f = 0; f < nfields; f++) begin
                if (f > 0) begin
                    sep = (f == 1) ? vst_pkg::CH_EQUAL : vst_pkg::CH_COLON;
                    // broken statements get a misplaced separator now and then
                    if (kind_draw < 20 && $urandom_range(0, 3) == 0) begin
                        case ($urandom_range(0, 2))
                            0: sep = vst_pkg::CH_COLON;
                            1: sep = vst_pkg::CH_EQUAL;
                            default: sep = vst_pkg::CH_QUERY;
                        endcase
                    end
                    stmt_bytes.push_back(sep);
                end
                add_field(long_form ? 90 : $urandom_range(0, 5));
            end
            if ($urandom_range(0, 3) == 0) begin
                stmt_bytes.push_back(vst_pkg::CH_QUERY);
                if (kind_draw < 20)
                    stmt_bytes.push_back(text_byte());
                else
                    repeat ($urandom_range(0, 2)) stmt_bytes.push_back(blank_byte());
            end
        end
        stmt_bytes.push_back($urandom_range(0, 1) ? vst_pkg::CH_SEMI : vst_pkg::CH_NUL);
    endtask

    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = draw_gap(send_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        bytes_sent++;
        if (c == vst_pkg::CH_NUL || c == vst_pkg::CH_SEMI)
            statements_sent++;
    endtask

    // receiver, with one long hold-off so that the result queue fills and the input stalls
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (taken == 200) begin
                i_out_ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            take_gap = draw_gap(take_calm);
            if (take_gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (take_gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do
                @(posedge i_clk);
            while (!o_out_valid);
            taken++;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_ch       <= vst_pkg::CH_NUL;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[k])
            send_byte(directed_bytes[k]);

        // one statement runs past the offset limit
        while (bytes_sent < 1880) begin
            build_statement(long_sent == 0 && bytes_sent > 300);
            if (long_sent == 0 && bytes_sent > 300)
                long_sent++;
            foreach (stmt_bytes[k])
                send_byte(stmt_bytes[k]);
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        $display("covered %0d bytes in %0d statements (%0d past the offset limit)",
                 bytes_sent, statements_sent, long_sent);
        $display("checked %0d field records and status results", results_seen);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== vsis_statement_tokenizer.f =====
sv/vst_pkg.sv
sv/vst_core.sv
sv/vst_res_fifo.sv
sv/vsis_statement_tokenizer.sv
test/vst_checker.sv
test/tb_top.sv
